[rtl/ahdlc_pkg.sv]
package ahdlc_pkg;

  localparam int unsigned CfgW        = 13;
  localparam int unsigned MaxFrameDef = 4096;
  localparam logic [CfgW-1:0] MaxLenReset = 13'd4096;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] FcsInit  = 16'hFFFF;
  localparam logic [15:0] FcsPoly  = 16'h8408;
  localparam logic [15:0] FcsGood  = 16'hF0B8;
  localparam logic [11:0] LenSat   = 12'hFFF;

  typedef enum logic [1:0] {
    OK_DATA  = 2'd0,
    OK_GOOD  = 2'd1,
    OK_BAD   = 2'd2,
    OK_ABORT = 2'd3
  } out_kind_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_OPEN = 4'b0010,
    PH_DATA = 4'b0100,
    PH_ESC  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } ahdlc_in_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [7:0]  payload_byte;
    logic [11:0] payload_len;
    logic        last;
  } ahdlc_out_t;

  // Reflected CRC-16 byte step, LSB first.
  function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] d);
    logic [15:0] v;
    v = {8'h00, fcs[7:0] ^ d};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ FcsPoly) : (v >> 1);
    end
    return {8'h00, fcs[15:8]} ^ v;
  endfunction

endpackage

[rtl/ahdlc_in_reg.sv]
module ahdlc_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ahdlc_pkg::ahdlc_in_t in_data_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output ahdlc_pkg::ahdlc_in_t dn_data_o
);
  import ahdlc_pkg::*;

  logic      valid_q, valid_d;
  ahdlc_in_t data_q;

  assign in_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

[rtl/ahdlc_deframer.sv]
module ahdlc_deframer #(
  parameter int unsigned MaxFrame = ahdlc_pkg::MaxFrameDef,
  localparam int unsigned CntW = $clog2(MaxFrame + 1),
  localparam int unsigned LimW = (CntW > ahdlc_pkg::CfgW) ? CntW : ahdlc_pkg::CfgW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [LimW-1:0]       lim_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ahdlc_pkg::ahdlc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ahdlc_pkg::ahdlc_out_t out_data_o
);
  import ahdlc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] fcs_q, fcs_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic        out_valid_q, out_valid_d;
  ahdlc_out_t  out_q, out_d;

  logic        fire;
  logic        take;
  logic [7:0]  dbyte;
  logic        res_valid;
  ahdlc_out_t  res;
  logic [LimW-1:0] len_full;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign len_full = LimW'(cnt_q) - LimW'(2);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    fcs_d     = fcs_q;
    hcnt_d    = hcnt_q;
    held_d    = held_q;
    take      = 1'b0;
    dbyte     = in_data_i.rx_byte;
    res_valid = 1'b0;
    res       = '0;

    if (fire) begin
      if (in_data_i.kind) begin
        // timeout: abort a frame in the data or escape phase, otherwise drop quietly
        if (phase_q == PH_DATA || phase_q == PH_ESC) begin
          res_valid    = 1'b1;
          res.out_kind = OK_ABORT;
          res.last     = 1'b1;
        end
        phase_d = PH_IDLE;
        cnt_d   = '0;
        fcs_d   = FcsInit;
        hcnt_d  = '0;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (dbyte == FlagByte) begin
              phase_d = PH_OPEN;
            end
          end
          PH_OPEN, PH_DATA: begin
            if (dbyte == FlagByte) begin
              if (phase_q == PH_DATA) begin
                res_valid    = 1'b1;
                res.last     = 1'b1;
                res.out_kind = OK_BAD;
                if (cnt_q >= CntW'(2)) begin
                  res.payload_len = (len_full > LimW'(LenSat)) ? LenSat : len_full[11:0];
                  if (fcs_q == FcsGood) begin
                    res.out_kind = OK_GOOD;
                  end
                end
                phase_d = PH_OPEN;
                cnt_d   = '0;
                fcs_d   = FcsInit;
                hcnt_d  = '0;
              end
            end else if (dbyte == EscByte) begin
              phase_d = PH_ESC;
            end else begin
              take = 1'b1;
            end
          end
          PH_ESC: begin
            if (dbyte == FlagByte || dbyte == EscByte) begin
              res_valid    = 1'b1;
              res.out_kind = OK_ABORT;
              res.last     = 1'b1;
              phase_d      = (dbyte == FlagByte) ? PH_OPEN : PH_IDLE;
              cnt_d        = '0;
              fcs_d        = FcsInit;
              hcnt_d       = '0;
            end else begin
              dbyte = in_data_i.rx_byte ^ EscXor;
              take  = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            fcs_d   = FcsInit;
            hcnt_d  = '0;
          end
        endcase
      end

      if (take) begin
        if (LimW'(cnt_q) >= lim_i) begin
          // overflow
          res_valid    = 1'b1;
          res.out_kind = OK_ABORT;
          res.last     = 1'b1;
          phase_d      = PH_IDLE;
          cnt_d        = '0;
          fcs_d        = FcsInit;
          hcnt_d       = '0;
        end else begin
          fcs_d   = fcs_step(fcs_q, dbyte);
          cnt_d   = cnt_q + CntW'(1);
          phase_d = PH_DATA;
          if (hcnt_q == 2'd2) begin
            res_valid        = 1'b1;
            res.out_kind     = OK_DATA;
            res.payload_byte = held_q[0];
            held_d[0]        = held_q[1];
            held_d[1]        = dbyte;
          end else begin
            held_d[hcnt_q[0]] = dbyte;
            hcnt_d            = hcnt_q + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire) begin
      out_valid_d = res_valid;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      fcs_q       <= FcsInit;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      fcs_q       <= fcs_d;
      hcnt_q      <= hcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (cnt_q == '0 && hcnt_q == '0 && fcs_q == FcsInit))
    else $error("idle with frame state left over");

  a_hold_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(hcnt_q) <= cnt_q && hcnt_q != 2'd3)
    else $error("delay line fill exceeds byte count");

  a_data_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid && res.out_kind == OK_DATA) |-> hcnt_q == 2'd2)
    else $error("payload byte sent before delay line filled");

  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.out_kind != OK_DATA)))
    else $error("last flag does not match result kind");
`endif

endmodule

[rtl/async_hdlc_deframer_fcs16_core.sv]
// Async HDLC/PPP receive deframer with CRC-16 FCS check.
// Path from input transfer to result valid: input register, then the
//   decode/CRC stage into the result register.
// Throughput: one item per cycle; stalls only when the result register is held.
// Reset (rst_ni low, async): hunting for a flag, no results pending,
//   max_frame_len back to 4096.
module async_hdlc_deframer_fcs16_core #(
  parameter int unsigned MaxFrame = ahdlc_pkg::MaxFrameDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // item channel: one line byte or one timeout event per transfer
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ahdlc_pkg::ahdlc_in_t      in_data_i,
  // result channel: payload byte, frame end or abort
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ahdlc_pkg::ahdlc_out_t     out_data_o,
  // max_frame_len write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ahdlc_pkg::CfgW-1:0] cfg_data_i
);
  import ahdlc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned LimW = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0] max_len_q, max_len_d;
  logic [LimW-1:0] lim;

  logic      s1_valid;
  logic      s1_ready;
  ahdlc_in_t s1_data;

  // Register always writable; user must keep writes between frames; unenforced.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_len_d = max_len_q;
    if (cfg_valid_i) begin
      max_len_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // Effective limit is the smaller of the register and the build-time cap.
  assign lim = (LimW'(max_len_q) < LimW'(MaxFrame)) ? LimW'(max_len_q) : LimW'(MaxFrame);

  ahdlc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .dn_valid_o (s1_valid),
    .dn_ready_i (s1_ready),
    .dn_data_o  (s1_data)
  );

  // Flag hunt, destuffing, FCS and two-byte delay line; result register inside.
  ahdlc_deframer #(
    .MaxFrame (MaxFrame)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
